### rtl/core/buddy_pkg.sv
package buddy_pkg;

  // node states of the tree
  localparam logic [1:0] NodeUnused = 2'd0;
  localparam logic [1:0] NodeFree   = 2'd1;
  localparam logic [1:0] NodeSplit  = 2'd2;
  localparam logic [1:0] NodeAlloc  = 2'd3;

  // result status codes
  localparam logic [1:0] StatusOk       = 2'd0;
  localparam logic [1:0] StatusBadSize  = 2'd1;
  localparam logic [1:0] StatusNoSpace  = 2'd2;
  localparam logic [1:0] StatusNotAlloc = 2'd3;

  // request kinds
  typedef enum logic {
    ActAlloc = 1'b0,
    ActFree  = 1'b1
  } action_e;

  localparam int unsigned PidW  = 16;
  localparam int unsigned SizeW = 16;
  localparam int unsigned AddrW = 10;

  // classified command from the front to the back
  typedef struct packed {
    action_e           action;
    logic              bad;
    logic [4:0]        target;
    logic [PidW-1:0]   pid;
    logic [AddrW-1:0]  addr;
  } cmd_t;

  // result item
  typedef struct packed {
    logic [1:0]       status;
    logic [AddrW-1:0] addr;
    logic [PidW-1:0]  owner;
  } res_t;

endpackage

### rtl/core/buddy_front.sv
module buddy_front #(
  parameter int unsigned Levels = 10
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                action_i,
  input  logic [15:0]         pid_i,
  input  logic [15:0]         size_i,
  input  logic [9:0]          addr_i,
  output logic                cmd_valid_o,
  input  logic                cmd_ready_i,
  output buddy_pkg::cmd_t     cmd_o
);
  import buddy_pkg::*;

  localparam int unsigned Depth = 2;

  cmd_t       fifo_q [Depth];
  logic [1:0] count_q, count_d;
  logic       wr_q, wr_d;
  logic       rd_q, rd_d;
  logic       push, pop;
  cmd_t       cls;
  logic [4:0] k;
  logic [16:0] space;

  // size class: smallest k with 2^k >= size
  always_comb begin
    space = 17'(1) << Levels;
    k = 5'd0;
    for (int i = 17; i >= 1; i--) begin
      if ({1'b0, size_i} <= (17'(1) << (i - 1))) k = 5'(i - 1);
    end
    cls.action = action_e'(action_i);
    cls.bad    = (size_i == 16'd0) || ({1'b0, size_i} > space);
    cls.target = 5'(Levels) - k;
    cls.pid    = pid_i;
    cls.addr   = addr_i;
  end

  assign in_ready_o  = (count_q != 2'd2);
  assign cmd_valid_o = (count_q != 2'd0);
  assign cmd_o       = fifo_q[rd_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = cmd_valid_o && cmd_ready_i;

  // queue pointers
  always_comb begin
    count_d = count_q + 2'(push) - 2'(pop);
    wr_d    = wr_q ^ push;
    rd_d    = rd_q ^ pop;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= 2'd0;
      wr_q    <= 1'b0;
      rd_q    <= 1'b0;
    end else begin
      count_q <= count_d;
      wr_q    <= wr_d;
      rd_q    <= rd_d;
    end
  end

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push) fifo_q[wr_q] <= cls;
  end

  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni) count_q != 2'd3)
    else $error("queue count overflow");
  a_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q == 2'd2 |-> !in_ready_o) else $error("ready while full");
  a_ptr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == 2'd0 || count_q == 2'd2) |-> wr_q == rd_q) else $error("pointer mismatch");

endmodule

### rtl/core/buddy_back.sv
module buddy_back #(
  parameter int unsigned Levels = 10
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cmd_valid_i,
  output logic            cmd_ready_o,
  input  buddy_pkg::cmd_t cmd_i,
  output logic            res_valid_o,
  input  logic            res_ready_i,
  output buddy_pkg::res_t res_o
);
  import buddy_pkg::*;

  localparam int unsigned Nodes = (2 << Levels) - 1;
  localparam int unsigned NW    = $clog2(Nodes + 1);
  localparam int unsigned DW    = $clog2(Levels + 2);

  // sequencer states
  localparam logic [3:0] SClear  = 4'd0;
  localparam logic [3:0] SIdle   = 4'd1;
  localparam logic [3:0] SRead   = 4'd2;
  localparam logic [3:0] SEval   = 4'd3;
  localparam logic [3:0] SUp     = 4'd4;
  localparam logic [3:0] SFRead  = 4'd5;
  localparam logic [3:0] SFEval  = 4'd6;
  localparam logic [3:0] SMRead  = 4'd7;
  localparam logic [3:0] SMEval  = 4'd8;
  localparam logic [3:0] SOwn    = 4'd9;
  localparam logic [3:0] SOut    = 4'd10;
  localparam logic [3:0] SOwnW   = 4'd11;
  localparam logic [3:0] SMerge  = 4'd12;
  localparam logic [3:0] SClrNode = 4'd13;
  localparam logic [3:0] SSetPar = 4'd14;
  localparam logic [3:0] SSibRd  = 4'd15;

  logic [1:0]  st_mem [Nodes];
  logic [15:0] own_mem [Nodes];
  logic [1:0]  st_rd_q;
  logic [15:0] own_rd_q;
  logic [NW-1:0] raddr;
  logic [NW-1:0] waddr;
  logic [1:0]  wdata;
  logic        we;
  logic        own_we;

  logic [3:0]    state_q, state_d;
  logic [NW-1:0] node_q, node_d;
  logic [DW-1:0] depth_q, depth_d;
  logic [AddrW:0] start_q, start_d;
  logic [NW-1:0] clr_q, clr_d;
  logic          wrap_q, wrap_d;
  cmd_t          cmd_q, cmd_d;
  res_t          res_q, res_d;
  logic          rv_q, rv_d;
  logic [AddrW:0] half;
  logic [NW-1:0] sib;
  logic [NW-1:0] par;

  // tree memories, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (we) st_mem[waddr] <= wdata;
    if (own_we) own_mem[node_q] <= cmd_q.pid;
    st_rd_q  <= st_mem[raddr];
    own_rd_q <= own_mem[node_q];
  end

  assign cmd_ready_o = (state_q == SIdle) && !rv_q;
  assign res_valid_o = rv_q;
  assign res_o       = res_q;

  always_comb begin
    half = (AddrW + 1)'(1) << (Levels - 32'(depth_q) - 1);
    sib  = node_q[0] ? node_q + NW'(1) : node_q - NW'(1);
    par  = (node_q - NW'(1)) >> 1;
  end

  // sequencer: alloc descends depth first with a climb on failure,
  // free descends by address then merges upward
  always_comb begin
    state_d = state_q; node_d = node_q; depth_d = depth_q; start_d = start_q;
    clr_d = clr_q; wrap_d = wrap_q; cmd_d = cmd_q; res_d = res_q; rv_d = rv_q;
    raddr = node_q; waddr = node_q; wdata = NodeUnused; we = 1'b0; own_we = 1'b0;
    if (rv_q && res_ready_i) rv_d = 1'b0;
    unique case (state_q)
      SClear: begin
        we = 1'b1; waddr = clr_q;
        wdata = (clr_q == '0) ? NodeFree : NodeUnused;
        clr_d = clr_q + NW'(1);
        if (clr_q == NW'(Nodes - 1)) state_d = SIdle;
      end
      SIdle: begin
        if (cmd_valid_i && !rv_q) begin
          cmd_d = cmd_i; node_d = '0; depth_d = '0; start_d = '0;
          res_d = '0;
          if (cmd_i.action == ActAlloc) begin
            if (cmd_i.bad) begin
              res_d.status = StatusBadSize; state_d = SOut;
            end else state_d = SRead;
          end else if ({1'b0, cmd_i.addr} >= ((AddrW + 1)'(1) << Levels)) begin
            res_d.status = StatusNotAlloc; state_d = SOut;
          end else state_d = SFRead;
        end
      end
      SRead: state_d = SEval;
      SEval: begin
        if (32'(depth_q) == 32'(cmd_q.target)) begin
          if (st_rd_q == NodeFree) begin
            we = 1'b1; wdata = NodeAlloc; state_d = SOwnW;
            res_d.addr = start_q[AddrW-1:0]; res_d.owner = cmd_q.pid;
          end else state_d = SUp;
        end else if (st_rd_q == NodeFree || st_rd_q == NodeSplit) begin
          // splitting: a free parent is marked split and both its children are written free
          if (st_rd_q == NodeFree) begin
            we = 1'b1; wdata = NodeSplit;
          end
          node_d = (node_q << 1) + NW'(1); depth_d = depth_q + DW'(1);
          state_d = (st_rd_q == NodeFree) ? SMRead : SRead;
        end else state_d = SUp;
      end
      SMRead: begin
        // fresh split: write right child free, then left free and descend
        we = 1'b1; waddr = node_q + NW'(1); wdata = NodeFree; state_d = SMEval;
      end
      SMEval: begin
        we = 1'b1; wdata = NodeFree; state_d = SRead;
      end
      SUp: begin
        // failed at node: try right sibling or climb
        if (node_q == '0) begin
          res_d.status = StatusNoSpace; state_d = SOut;
        end else if (node_q[0]) begin
          node_d = node_q + NW'(1);
          start_d = start_q + ((AddrW + 1)'(1) << (Levels - 32'(depth_q)));
          state_d = SRead;
        end else begin
          node_d = par; depth_d = depth_q - DW'(1);
          start_d = start_q - ((AddrW + 1)'(1) << (Levels - 32'(depth_q)));
        end
      end
      SOwnW: begin
        own_we = 1'b1; state_d = SOut;
      end
      SFRead: state_d = SFEval;
      SFEval: begin
        if (st_rd_q == NodeAlloc) begin
          if (start_q[AddrW-1:0] == cmd_q.addr) state_d = SOwn;
          else begin
            res_d.status = StatusNotAlloc; state_d = SOut;
          end
        end else if (st_rd_q != NodeSplit || 32'(depth_q) >= Levels) begin
          res_d.status = StatusNotAlloc; state_d = SOut;
        end else begin
          if ({1'b0, cmd_q.addr} >= start_q + half) begin
            node_d = (node_q << 1) + NW'(2); start_d = start_q + half;
          end else node_d = (node_q << 1) + NW'(1);
          depth_d = depth_q + DW'(1); state_d = SFRead;
        end
      end
      SOwn: begin
        // owner read lands next; free the node
        we = 1'b1; wdata = NodeFree; wrap_d = 1'b1;
        res_d.addr = cmd_q.addr; state_d = SOut;
        if (node_q != '0) begin
          raddr = sib; state_d = SMerge;
        end
      end
      SMerge: begin
        // owner is taken on the first visit only
        if (wrap_q) begin
          res_d.owner = own_rd_q; wrap_d = 1'b0;
        end
        if (st_rd_q == NodeFree) begin
          we = 1'b1; waddr = sib; wdata = NodeUnused; state_d = SClrNode;
        end else state_d = SOut;
      end
      SClrNode: begin
        we = 1'b1; wdata = NodeUnused; state_d = SSetPar;
      end
      SSetPar: begin
        we = 1'b1; waddr = par; wdata = NodeFree; node_d = par;
        if (par == '0) state_d = SOut;
        else state_d = SSibRd;
      end
      SSibRd: begin
        raddr = sib; state_d = SMerge;
      end
      SOut: begin
        if (wrap_q) begin
          res_d.owner = own_rd_q; wrap_d = 1'b0;
        end
        rv_d = 1'b1; state_d = SIdle;
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SClear; clr_q <= '0; rv_q <= 1'b0; wrap_q <= 1'b0;
    end else begin
      state_q <= state_d; clr_q <= clr_d; rv_q <= rv_d; wrap_q <= wrap_d;
    end
  end

  always_ff @(posedge clk_i) begin
    node_q <= node_d; depth_q <= depth_d; start_q <= start_d;
    cmd_q <= cmd_d; res_q <= res_d;
  end

  a_rdy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_ready_o |-> state_q == SIdle) else $error("ready outside idle");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rv_q && !res_ready_i |=> rv_q) else $error("result dropped");
  a_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rv_q && res_q.status != StatusOk |-> res_q.addr == '0) else $error("error with address");

endmodule

### rtl/core/buddy_allocator_unit.sv
// channel   dir  tdata fields (low first)                         tuser
// s_axis    in   process_id[15:0] request_size[31:16] addr[41:32] action
// m_axis    out  status[1:0] block_address[11:2] block_owner[27:12] -
// the state memory paces the walk: a descent reads and evaluates each level,
// a failed node adds a step to try its sibling or climb, a fresh split writes
// both children free, a merge frees the parent; then the item is handed out
// after reset the state memory is cleared node by node, no items taken
// a queue of two items parts the classifier from the tree walker
module buddy_allocator_unit #(
  parameter int unsigned TOTAL_UNITS = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,  // process_id, request_size, free_address
  input  logic        s_axis_tuser,  // action
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata   // status, block_address, block_owner
);
  import buddy_pkg::*;

  localparam int unsigned Levels = $clog2(TOTAL_UNITS + 1) - 1;

  cmd_t cmd;
  logic cmd_valid, cmd_ready;
  res_t res;

  buddy_front #(.Levels(Levels)) u_front (
    .clk_i, .rst_ni,
    .in_valid_i (s_axis_tvalid), .in_ready_o (s_axis_tready),
    .action_i (s_axis_tuser), .pid_i (s_axis_tdata[15:0]),
    .size_i (s_axis_tdata[31:16]), .addr_i (s_axis_tdata[41:32]),
    .cmd_valid_o (cmd_valid), .cmd_ready_i (cmd_ready), .cmd_o (cmd)
  );

  buddy_back #(.Levels(Levels)) u_back (
    .clk_i, .rst_ni,
    .cmd_valid_i (cmd_valid), .cmd_ready_o (cmd_ready), .cmd_i (cmd),
    .res_valid_o (m_axis_tvalid), .res_ready_i (m_axis_tready), .res_o (res)
  );

  assign m_axis_tdata = {4'd0, res.owner, res.addr, res.status};

endmodule
